@@ rtl/core/tod_pkg.sv @@
// Shared types and constants for the tilt orientation debouncer.
package tod_pkg;

    // Configuration field widths
    localparam int LEVEL_WIDTH  = 15;
    localparam int RATIO_WIDTH  = 10;
    localparam int STREAK_WIDTH = 8;

    // APB port geometry
    localparam int PADDR_WIDTH = 4;
    localparam int PDATA_WIDTH = 32;

    // Reset values of the configuration registers
    localparam logic [LEVEL_WIDTH-1:0]  LEVEL_RESET  = 15'd2662;
    localparam logic [RATIO_WIDTH-1:0]  RATIO_RESET  = 10'd294;
    localparam logic [STREAK_WIDTH-1:0] STREAK_RESET = 8'd3;

    // Depth of the queue between classifier and debouncer
    localparam int QUEUE_DEPTH = 2;

    // Register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_MIN_LEVEL = 2'd0,
        REG_RATIO     = 2'd1,
        REG_STREAK    = 2'd2,
        REG_NONE      = 2'd3
    } reg_index_t;

    // Screen rotation codes
    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } rotation_t;

    // Classified sample handed from front to back
    typedef struct packed {
        logic      accepted;
        rotation_t rot;
    } sample_class_t;

    // Result item payload
    typedef struct packed {
        logic      rotation_changed;
        rotation_t committed_rotation;
        logic      committed_valid;
    } result_t;

endpackage

@@ rtl/core/tod_ifs.sv @@
// Valid/ready channel interfaces for samples and results.
interface tod_sample_if #(parameter int SAMPLE_WIDTH = 16);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] accel_x;
    logic signed [SAMPLE_WIDTH-1:0] accel_y;

    modport source (output valid, accel_x, accel_y, input ready);
    modport sink   (input valid, accel_x, accel_y, output ready);
endinterface

interface tod_result_if;
    logic       valid;
    logic       ready;
    logic       rotation_changed;
    logic [1:0] committed_rotation;
    logic       committed_valid;

    modport source (output valid, rotation_changed, committed_rotation, committed_valid,
                    input ready);
    modport sink   (input valid, rotation_changed, committed_rotation, committed_valid,
                    output ready);
endinterface

@@ rtl/core/tod_front.sv @@
// Front end: accept sample items and classify them into a rotation or a reject.
module tod_front #(
    parameter int SAMPLE_WIDTH = 16
) (
    tod_sample_if.sink                        sample_in,
    input  logic [tod_pkg::LEVEL_WIDTH-1:0]   min_dominant_level,
    input  logic [tod_pkg::RATIO_WIDTH-1:0]   dominance_ratio,
    input  logic                              queue_full,
    output logic                              push_valid,
    output tod_pkg::sample_class_t            push_data
);
    import tod_pkg::*;

    localparam int PROD_WIDTH = SAMPLE_WIDTH + RATIO_WIDTH;

    logic                    neg_x;
    logic                    neg_y;
    logic [SAMPLE_WIDTH-1:0] mag_x;
    logic [SAMPLE_WIDTH-1:0] mag_y;
    logic                    x_dom;
    logic [SAMPLE_WIDTH-1:0] dom;
    logic [SAMPLE_WIDTH-1:0] oth;
    logic [PROD_WIDTH-1:0]   dom_scaled;
    logic [PROD_WIDTH-1:0]   oth_scaled;
    logic                    below_level;
    logic                    diagonal;

    // Accept whenever the queue has room
    assign sample_in.ready = !queue_full;
    assign push_valid      = sample_in.valid && !queue_full;

    // Take magnitudes; the most negative code maps to 2^(W-1) exactly
    assign neg_x = sample_in.accel_x[SAMPLE_WIDTH-1];
    assign neg_y = sample_in.accel_y[SAMPLE_WIDTH-1];
    assign mag_x = neg_x ? (~sample_in.accel_x + 1'b1) : sample_in.accel_x;
    assign mag_y = neg_y ? (~sample_in.accel_y + 1'b1) : sample_in.accel_y;

    // Pick the dominant axis
    assign x_dom = mag_x >= mag_y;
    assign dom   = x_dom ? mag_x : mag_y;
    assign oth   = x_dom ? mag_y : mag_x;

    // Threshold and dead band tests
    assign dom_scaled  = {2'b00, dom, 8'h00};
    assign oth_scaled  = PROD_WIDTH'(oth) * PROD_WIDTH'(dominance_ratio);
    assign below_level = PROD_WIDTH'(dom) < PROD_WIDTH'(min_dominant_level);
    assign diagonal    = dom_scaled < oth_scaled;

    // Map dominant axis and sign to a rotation
    always_comb
    begin
        push_data.accepted = !below_level && !diagonal;
        if (x_dom)
        begin
            push_data.rot = neg_x ? ROT_270 : ROT_90;
        end
        else
        begin
            push_data.rot = neg_y ? ROT_180 : ROT_0;
        end
    end

endmodule

@@ rtl/core/tod_queue.sv @@
// Short FIFO of classified items between front and back.
module tod_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push_valid,
    input  tod_pkg::sample_class_t push_data,
    output logic                   queue_full,
    input  logic                   pop_ready,
    output logic                   pop_valid,
    output tod_pkg::sample_class_t pop_data
);
    import tod_pkg::*;

    localparam int PTR_WIDTH  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_WIDTH = $clog2(QUEUE_DEPTH + 1);

    sample_class_t          entry_reg [QUEUE_DEPTH];
    logic [PTR_WIDTH-1:0]   wr_ptr_reg;
    logic [PTR_WIDTH-1:0]   wr_ptr_next;
    logic [PTR_WIDTH-1:0]   rd_ptr_reg;
    logic [PTR_WIDTH-1:0]   rd_ptr_next;
    logic [FILL_WIDTH-1:0]  fill_reg;
    logic [FILL_WIDTH-1:0]  fill_next;
    logic                   do_push;
    logic                   do_pop;

    assign queue_full = fill_reg == FILL_WIDTH'(QUEUE_DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && !queue_full;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Fill count never passes the depth
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_WIDTH'(QUEUE_DEPTH))
        else $error("queue fill count above depth");

    // A pop with a push keeps the fill count
    assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && do_pop) |=> $stable(fill_reg))
        else $error("queue fill changed on simultaneous push and pop");

    // Pointers agree whenever the queue is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree while empty");

endmodule

@@ rtl/core/tod_back.sv @@
// Back end: debounce classified items and register the result item.
module tod_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [tod_pkg::STREAK_WIDTH-1:0]  required_streak,
    input  logic                              pop_valid,
    input  tod_pkg::sample_class_t            pop_data,
    output logic                              pop_ready,
    tod_result_if.source                      result_out
);
    import tod_pkg::*;

    rotation_t               pending_orientation_reg;
    rotation_t               pending_orientation_next;
    logic                    pending_present_reg;
    logic                    pending_present_next;
    logic [STREAK_WIDTH-1:0] streak_count_reg;
    logic [STREAK_WIDTH-1:0] streak_count_next;
    rotation_t               held_orientation_reg;
    rotation_t               held_orientation_next;
    logic                    held_present_reg;
    logic                    held_present_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    result_t                 out_data_reg;
    result_t                 out_data_next;
    logic [STREAK_WIDTH-1:0] need;
    logic                    step;
    logic                    changed;

    // Take an item when the output register is free or being drained
    assign pop_ready = !out_valid_reg || result_out.ready;
    assign step      = pop_valid && pop_ready;
    assign need      = (required_streak == '0) ? STREAK_WIDTH'(1) : required_streak;

    // Streak and commit update
    always_comb
    begin
        pending_orientation_next = pending_orientation_reg;
        pending_present_next     = pending_present_reg;
        streak_count_next        = streak_count_reg;
        held_orientation_next    = held_orientation_reg;
        held_present_next        = held_present_reg;
        changed                  = 1'b0;
        if (!pop_data.accepted)
        begin
            pending_present_next     = 1'b0;
            pending_orientation_next = ROT_0;
            streak_count_next        = '0;
        end
        else
        begin
            if (!pending_present_reg || pending_orientation_reg != pop_data.rot)
            begin
                pending_present_next     = 1'b1;
                pending_orientation_next = pop_data.rot;
                streak_count_next        = STREAK_WIDTH'(1);
            end
            else if (streak_count_reg < need)
            begin
                streak_count_next = streak_count_reg + 1'b1;
            end
            if (streak_count_next >= need)
            begin
                changed = !held_present_reg || held_orientation_reg != pop_data.rot;
                held_orientation_next    = pop_data.rot;
                held_present_next        = 1'b1;
                pending_present_next     = 1'b0;
                pending_orientation_next = ROT_0;
                streak_count_next        = '0;
            end
        end
    end

    // Load or drain the output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (step)
        begin
            out_valid_next                   = 1'b1;
            out_data_next.rotation_changed   = changed;
            out_data_next.committed_rotation = held_orientation_next;
            out_data_next.committed_valid    = held_present_next;
        end
        else if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_orientation_reg <= ROT_0;
            pending_present_reg     <= 1'b0;
            streak_count_reg        <= '0;
            held_orientation_reg    <= ROT_0;
            held_present_reg        <= 1'b0;
            out_valid_reg           <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (step)
            begin
                pending_orientation_reg <= pending_orientation_next;
                pending_present_reg     <= pending_present_next;
                streak_count_reg        <= streak_count_next;
                held_orientation_reg    <= held_orientation_next;
                held_present_reg        <= held_present_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    // Drive the result channel
    assign result_out.valid              = out_valid_reg;
    assign result_out.rotation_changed   = out_data_reg.rotation_changed;
    assign result_out.committed_rotation = out_data_reg.committed_rotation;
    assign result_out.committed_valid    = out_data_reg.committed_valid;

    // No streak is counted without a pending rotation
    assert property (@(posedge clk) disable iff (!rst_n)
        !pending_present_reg |-> (streak_count_reg == '0))
        else $error("streak count without pending rotation");

    // Once committed, a rotation stays committed
    assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(held_present_reg))
        else $error("committed flag dropped");

    // A reported change always comes with a valid committed rotation
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.rotation_changed) |-> out_data_reg.committed_valid)
        else $error("rotation change without committed rotation");

    // A reported change matches the held rotation just stored
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && changed) |=> (out_data_reg.committed_rotation == held_orientation_reg))
        else $error("reported rotation differs from held rotation");

endmodule

@@ rtl/core/tilt_orientation_debouncer_unit.sv @@
// Top level of the tilt orientation debouncer: config registers, front, queue, back.
//
//   channel      direction  handshake      payload
//   sample_in    in         valid/ready    accel_x, accel_y (signed, SAMPLE_WIDTH)
//   result_out   out        valid/ready    rotation_changed, committed_rotation,
//                                          committed_valid
//   apb          in         psel/penable   paddr[3:0], pwdata, prdata (32 bit)
//
// One item per cycle sustained while result_out is ready; each item passes through
// the queue register and the output register on its way to result_out.
// The classify path (magnitude, one SAMPLE_WIDTH x 10 multiply, compare) is the
// longest path. Reset clears the streak, the committed rotation and the queue,
// and loads the register defaults. A stalled result_out fills the two-entry queue,
// after which sample_in.ready drops.
module tilt_orientation_debouncer_unit #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tod_pkg::PADDR_WIDTH-1:0]    paddr,
    input  logic [tod_pkg::PDATA_WIDTH-1:0]    pwdata,
    output logic [tod_pkg::PDATA_WIDTH-1:0]    prdata,
    output logic                               pready,
    tod_sample_if.sink                         sample_in,
    tod_result_if.source                       result_out
);
    import tod_pkg::*;

    logic [LEVEL_WIDTH-1:0]  min_dominant_level_reg;
    logic [RATIO_WIDTH-1:0]  dominance_ratio_reg;
    logic [STREAK_WIDTH-1:0] required_streak_reg;
    reg_index_t              reg_index;
    logic                    cfg_write;
    logic                    push_valid;
    sample_class_t           push_data;
    logic                    queue_full;
    logic                    pop_valid;
    logic                    pop_ready;
    sample_class_t           pop_data;

    // Decode the APB access
    assign pready    = 1'b1;
    assign reg_index = reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    // Write the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_dominant_level_reg <= LEVEL_RESET;
            dominance_ratio_reg    <= RATIO_RESET;
            required_streak_reg    <= STREAK_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                REG_MIN_LEVEL: min_dominant_level_reg <= pwdata[LEVEL_WIDTH-1:0];
                REG_RATIO:     dominance_ratio_reg    <= pwdata[RATIO_WIDTH-1:0];
                REG_STREAK:    required_streak_reg    <= pwdata[STREAK_WIDTH-1:0];
                REG_NONE:      ;
                default:       ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (reg_index)
            REG_MIN_LEVEL: prdata = PDATA_WIDTH'(min_dominant_level_reg);
            REG_RATIO:     prdata = PDATA_WIDTH'(dominance_ratio_reg);
            REG_STREAK:    prdata = PDATA_WIDTH'(required_streak_reg);
            default:       prdata = '0;
        endcase
    end

    tod_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .sample_in          (sample_in),
        .min_dominant_level (min_dominant_level_reg),
        .dominance_ratio    (dominance_ratio_reg),
        .queue_full         (queue_full),
        .push_valid         (push_valid),
        .push_data          (push_data)
    );

    tod_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .queue_full (queue_full),
        .pop_ready  (pop_ready),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data)
    );

    tod_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .required_streak (required_streak_reg),
        .pop_valid       (pop_valid),
        .pop_data        (pop_data),
        .pop_ready       (pop_ready),
        .result_out      (result_out)
    );

endmodule
